FILE: hw/rtl/signed_int_to_decimal_ascii_assert.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii assertion macros
// shared property templates for the converter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define S2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define S2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg
// shared constants for the signed binary to decimal ascii converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package s2d_pkg;

  localparam int unsigned ValueBitsDefault = 32;
  // decimal digits needed for a value of ValueBitsDefault bits
  localparam int unsigned DigitsDefault    = (ValueBitsDefault * 30103) / 100000 + 1;

  localparam int unsigned BcdBits = 4;
  localparam logic [BcdBits-1:0] BcdAdjLimit = 4'd5;
  localparam logic [BcdBits-1:0] BcdAdjust   = 4'd3;

  localparam logic [7:0] AsciiZero  = 8'd48;
  localparam logic [7:0] AsciiMinus = 8'd45;

endpackage

`default_nettype wire

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed integer to decimal ascii text, one character per output beat
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : value_i with in_valid_i / in_ready_o, one number per beat.
//   out channel : char_code_o, last_char_o with out_valid_o / out_ready_i.
//   Each number yields its text most significant first: '-' for negative
//   values, then the digits with no leading zeros; zero gives a single '0'.
//   last_char_o marks the final character of the number.
//   Timing: after an input beat the magnitude is turned into bcd by one
//   shift-and-add-3 step per cycle, then leading zero digits are dropped
//   (up to 9 at 32 bits) before the first character shows. Characters
//   then leave at one per cycle while the receiver is ready, up to 11 per
//   number at 32 bits. in_ready_o rises the cycle after the last
//   character's beat. A number holds the block from its input beat until
//   its last character's beat, so no new number is taken before then.
//   A stalled receiver just holds the current character; nothing is lost.
//   Reset returns the block to idle, ready for a number, with no output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = s2d_pkg::ValueBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   char_code_o,
  output logic                         last_char_o
);

  `include "signed_int_to_decimal_ascii_assert.svh"

  localparam int unsigned Digits = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned NibW   = s2d_pkg::BcdBits;
  localparam int unsigned BcdW   = NibW * Digits;
  localparam int unsigned CntW   = $clog2(VALUE_BITS + 1);
  localparam int unsigned DigW   = $clog2(Digits + 1);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StConv = 5'b00010,
    StSkip = 5'b00100,
    StSign = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [BcdW-1:0]     bcd_q, bcd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DigW-1:0]     dig_q, dig_d;

  logic [VALUE_BITS-1:0] value_u;
  logic [BcdW-1:0]       bcd_step;
  logic [NibW-1:0]       top_nib;
  logic                  in_beat;
  logic                  out_beat;

  assign value_u  = value_i;
  assign top_nib  = bcd_q[BcdW-1 -: NibW];
  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  s2d_dabble #(
    .Digits (Digits)
  ) u_dabble (
    .bcd_i (bcd_q),
    .bit_i (mag_q[VALUE_BITS-1]),
    .bcd_o (bcd_step)
  );

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    dig_d   = dig_q;
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          neg_d = value_u[VALUE_BITS-1];
          // most negative pattern negates to itself, which is the true magnitude
          mag_d = value_u[VALUE_BITS-1] ? (~value_u + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                                        : value_u;
          bcd_d   = '0;
          cnt_d   = CntW'(VALUE_BITS);
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = bcd_step;
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          dig_d   = DigW'(Digits);
          state_d = StSkip;
        end
      end
      StSkip: begin
        // drop leading zeros, keeping at least the units digit
        if (top_nib == '0 && dig_q != DigW'(1)) begin
          bcd_d = {bcd_q[BcdW-NibW-1:0], {NibW{1'b0}}};
          dig_d = dig_q - DigW'(1);
        end else begin
          state_d = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (out_beat) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_beat) begin
          bcd_d = {bcd_q[BcdW-NibW-1:0], {NibW{1'b0}}};
          dig_d = dig_q - DigW'(1);
          if (dig_q == DigW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      dig_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      dig_q   <= dig_d;
      neg_q   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StSign) || (state_q == StEmit);
  assign char_code_o = (state_q == StSign) ? s2d_pkg::AsciiMinus
                                           : (s2d_pkg::AsciiZero + {4'b0000, top_nib});
  assign last_char_o = (state_q == StEmit) && (dig_q == DigW'(1));

  `S2D_ASSERT_NOW(a_ready_excl_valid, in_ready_o, !out_valid_o, "ready while output pending")
  `S2D_ASSERT_NEXT(a_last_to_idle, out_beat && last_char_o, in_ready_o, "no idle after last beat")
  `S2D_ASSERT_NOW(a_digit_bcd, state_q == StEmit, top_nib <= 4'd9, "digit beat not bcd")
  `S2D_ASSERT_NOW(a_sign_neg, state_q == StSign, neg_q, "sign beat for non-negative value")

endmodule

`default_nettype wire

FILE: hw/rtl/s2d_dabble.sv
// ----------------------------------------------------------------------------
// s2d_dabble
// one shift-and-add-3 step of the binary to bcd conversion
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s2d_dabble #(
  parameter int unsigned Digits = s2d_pkg::DigitsDefault
) (
  input  logic [s2d_pkg::BcdBits*Digits-1:0] bcd_i,
  input  logic                               bit_i,
  output logic [s2d_pkg::BcdBits*Digits-1:0] bcd_o
);

  localparam int unsigned BcdW = s2d_pkg::BcdBits * Digits;

  logic [BcdW-1:0] adj;

  // every digit lane of five or more gets three added before the shift
  always_comb begin
    logic [s2d_pkg::BcdBits-1:0] nib;
    adj = '0;
    for (int unsigned i = 0; i < Digits; i++) begin
      nib = bcd_i[s2d_pkg::BcdBits*i +: s2d_pkg::BcdBits];
      if (nib >= s2d_pkg::BcdAdjLimit) begin
        adj[s2d_pkg::BcdBits*i +: s2d_pkg::BcdBits] = nib + s2d_pkg::BcdAdjust;
      end else begin
        adj[s2d_pkg::BcdBits*i +: s2d_pkg::BcdBits] = nib;
      end
    end
  end

  assign bcd_o = {adj[BcdW-2:0], bit_i};

endmodule

`default_nettype wire
